>>> rtl/core/stpe_pkg.sv
package stpe_pkg;

  localparam int SAMPLE_W = 32;
  localparam int RANGE_W  = 31;
  localparam int COORD_W  = 8;
  localparam int ROW_W    = 8;
  localparam int PEAK_W   = 32;
  // The divisor is twice the range limit; the dividend is (s + r) * (height - 1).
  localparam int DEN_W    = RANGE_W + 1;
  localparam int SUM_W    = SAMPLE_W + 1;
  localparam int NUM_W    = SUM_W + ROW_W;
  localparam int QUO_W    = ROW_W;

  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(1024);

  localparam int SCREEN_WIDTH_DEF   = 160;
  localparam int SCREEN_HEIGHT_DEF  = 128;
  localparam int GRID_DIVISIONS_DEF = 4;

  typedef enum logic [1:0] {
    KIND_LINE   = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_REPORT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    COLOUR_BG    = 2'd0,
    COLOUR_TRACE = 2'd1,
    COLOUR_GRID  = 2'd2
  } colour_e;

  typedef struct packed {
    kind_e                      kind;
    logic [COORD_W-1:0]         start_x;
    logic [COORD_W-1:0]         start_y;
    logic [COORD_W-1:0]         end_x;
    logic [COORD_W-1:0]         end_y;
    colour_e                    colour;
    logic signed [PEAK_W-1:0]   shown_peak;
    logic signed [PEAK_W-1:0]   erased_peak;
    logic                       last;
  } cmd_t;

endpackage

>>> rtl/core/stpe_if.sv
interface stpe_sample_if
  import stpe_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface stpe_cmd_if
  import stpe_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               command_kind;
  logic [COORD_W-1:0]       start_x;
  logic [COORD_W-1:0]       start_y;
  logic [COORD_W-1:0]       end_x;
  logic [COORD_W-1:0]       end_y;
  logic [1:0]               colour;
  logic signed [PEAK_W-1:0] shown_peak;
  logic signed [PEAK_W-1:0] erased_peak;
  logic                     last;

  modport source (
    output valid, output command_kind, output start_x, output start_y,
    output end_x, output end_y, output colour, output shown_peak,
    output erased_peak, output last, input ready
  );
  modport sink (
    input valid, input command_kind, input start_x, input start_y,
    input end_x, input end_y, input colour, input shown_peak,
    input erased_peak, input last, output ready
  );
endinterface

>>> rtl/core/sweep_trace_plot_engine.sv
// Sweep-mode trace plotter. Each sample transfer is clamped to plus or minus the
// range limit, folded into the sweep peak, mapped to a screen row and stored for
// its column; the block then issues drawing commands one per cycle on the command
// channel while the sink accepts them: an erase of the segment ahead, but not at
// the end of a sweep, the new trace segment and the grid pixels of the next
// column, and at the end of a sweep a peak report, the grid of column zero and
// an erase of the first segment. A sample is taken only when the previous one
// has issued all its commands. After a sample transfer, S_PREP forms the scaled
// dividend and S_RD1 starts a restoring divide by twice the range limit, while
// the three row-store reads share the single read port. S_DIV takes the quotient
// once the divide is done, so the divide sets the pace before the first command.
// A sample then gives GRID_DIVISIONS+1 commands, or 2*GRID_DIVISIONS+1 at the end
// of a sweep, and the next sample can be taken in the cycle after the last command
// issues. The row store is cleared by per-entry valid bits, so there is no
// clearing pass after reset.
module sweep_trace_plot_engine
  import stpe_pkg::*;
#(
  parameter int SCREEN_WIDTH   = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = SCREEN_HEIGHT_DEF,
  parameter int GRID_DIVISIONS = GRID_DIVISIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RANGE_W-1:0] cfg_wdata_i,
  stpe_sample_if.sink        sample_i,
  stpe_cmd_if.source         cmd_o
);

  localparam int CW        = $clog2(SCREEN_WIDTH);
  localparam int KW        = $clog2(GRID_DIVISIONS);
  localparam int GRID_STEP = SCREEN_HEIGHT / GRID_DIVISIONS;
  localparam logic [CW-1:0]    COL_LAST = CW'(SCREEN_WIDTH - 2);
  localparam logic [KW-1:0]    K_LAST   = KW'(GRID_DIVISIONS - 1);
  localparam logic [ROW_W-1:0] H_M1     = ROW_W'(SCREEN_HEIGHT - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_RD1, S_RD2, S_RD3, S_DIV,
    S_ERASE, S_TRACE, S_GRID, S_REPORT, S_GRID0, S_WRAP
  } state_e;

  state_e                     state_q;
  logic [RANGE_W-1:0]         range_q;
  logic signed [PEAK_W-1:0]   s_q, peak_q, prev_q;
  logic [RANGE_W-1:0]         r_q;
  logic [NUM_W-1:0]           num_q;
  logic [CW-1:0]              col_q;
  logic [ROW_W-1:0]           row_c_q, row_a_q, row_b_q, row_new_q;
  logic [KW-1:0]              k_q;
  logic                       out_valid_q;
  cmd_t                       cmd_q, cmd_d;
  logic [SCREEN_WIDTH-1:0]    vld_q;
  logic                       rvld_q;

  // Clamp and scaling terms.
  logic [RANGE_W-1:0]         r_eff;
  logic signed [SUM_W-1:0]    s_ext, r_ext, s_clip;
  logic [SUM_W-1:0]           sum_u;
  logic [NUM_W-1:0]           num_d;
  logic [PEAK_W-1:0]          s_abs, p_abs;

  logic                       wrap, out_free, emit, accept;
  logic [COORD_W-1:0]         c8;
  logic [ROW_W-1:0]           grid_y, rd_row, row_calc;

  logic                       div_start, div_done;
  logic [QUO_W-1:0]           div_quo;

  logic                       ram_we;
  logic [CW-1:0]              ram_waddr, ram_raddr;
  logic [ROW_W-1:0]           ram_wdata, ram_rdata;

  assign accept   = sample_i.valid && sample_i.ready;
  assign wrap     = (col_q == COL_LAST);
  assign out_free = !out_valid_q || cmd_o.ready;
  assign emit     = out_free && (state_q == S_ERASE || state_q == S_TRACE ||
                                 state_q == S_GRID || state_q == S_REPORT ||
                                 state_q == S_GRID0 || state_q == S_WRAP);
  assign c8       = COORD_W'(col_q);
  assign grid_y   = ROW_W'(GRID_STEP * k_q);
  assign rd_row   = rvld_q ? ram_rdata : '0;
  assign row_calc = H_M1 - div_quo;

  always_comb begin
    r_eff  = (range_q == '0) ? RANGE_W'(1) : range_q;
    r_ext  = signed'({2'b00, r_eff});
    s_ext  = signed'({sample_i.sample[SAMPLE_W-1], sample_i.sample});
    if (s_ext > r_ext) begin
      s_clip = r_ext;
    end else if (s_ext < -r_ext) begin
      s_clip = -r_ext;
    end else begin
      s_clip = s_ext;
    end
    sum_u = SUM_W'(signed'({s_q[PEAK_W-1], s_q}) + signed'({2'b00, r_q}));
    num_d = NUM_W'(sum_u) * NUM_W'(H_M1);
    s_abs = s_q[PEAK_W-1] ? PEAK_W'(-s_q) : PEAK_W'(s_q);
    p_abs = peak_q[PEAK_W-1] ? PEAK_W'(-peak_q) : PEAK_W'(peak_q);
  end

  // Row store: at the end of a sweep the reads fetch rows 0 and 1 for the
  // first-segment erase instead of the segment ahead, which is not drawn then.
  always_comb begin
    case (state_q)
      S_RD1:   ram_raddr = wrap ? '0 : col_q + CW'(1);
      S_RD2:   ram_raddr = wrap ? CW'(1) : col_q + CW'(2);
      default: ram_raddr = col_q;
    endcase
    ram_we    = (state_q == S_DIV && div_done) || (state_q == S_WRAP && emit);
    ram_waddr = (state_q == S_WRAP) ? '0 : col_q + CW'(1);
    ram_wdata = (state_q == S_WRAP) ? row_new_q : row_calc;
  end

  assign div_start = (state_q == S_RD1);

  stpe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   ({r_q, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  stpe_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SCREEN_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      rvld_q <= vld_q[ram_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_RESET;
    end else if (cfg_we_i) begin
      range_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cmd_d = '0;
    cmd_d.kind   = KIND_LINE;
    cmd_d.colour = COLOUR_BG;
    case (state_q)
      S_ERASE: begin
        cmd_d.start_x = c8 + COORD_W'(1);
        cmd_d.start_y = row_a_q;
        cmd_d.end_x   = c8 + COORD_W'(2);
        cmd_d.end_y   = row_b_q;
      end
      S_TRACE: begin
        cmd_d.start_x = c8;
        cmd_d.start_y = row_c_q;
        cmd_d.end_x   = c8 + COORD_W'(1);
        cmd_d.end_y   = row_new_q;
        cmd_d.colour  = COLOUR_TRACE;
      end
      S_GRID: begin
        cmd_d.kind    = KIND_PIXEL;
        cmd_d.start_x = c8 + COORD_W'(1);
        cmd_d.start_y = grid_y;
        cmd_d.colour  = COLOUR_GRID;
        cmd_d.last    = (k_q == K_LAST) && !wrap;
      end
      S_REPORT: begin
        cmd_d.kind        = KIND_REPORT;
        cmd_d.colour      = COLOUR_TRACE;
        cmd_d.shown_peak  = peak_q;
        cmd_d.erased_peak = prev_q;
      end
      S_GRID0: begin
        cmd_d.kind    = KIND_PIXEL;
        cmd_d.start_y = grid_y;
        cmd_d.colour  = COLOUR_GRID;
      end
      S_WRAP: begin
        cmd_d.start_y = row_a_q;
        cmd_d.end_x   = COORD_W'(1);
        cmd_d.end_y   = row_b_q;
        cmd_d.last    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      peak_q      <= '0;
      prev_q      <= '0;
      k_q         <= KW'(1);
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        cmd_q       <= cmd_d;
      end else if (cmd_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            s_q     <= s_clip[PEAK_W-1:0];
            r_q     <= r_eff;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          num_q <= num_d;
          if (s_abs > p_abs) begin
            peak_q <= s_q;
          end
          state_q <= S_RD1;
        end
        S_RD1: begin
          row_c_q <= rd_row;
          state_q <= S_RD2;
        end
        S_RD2: begin
          row_a_q <= rd_row;
          state_q <= S_RD3;
        end
        S_RD3: begin
          row_b_q <= rd_row;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            row_new_q <= row_calc;
            k_q       <= KW'(1);
            state_q   <= wrap ? S_TRACE : S_ERASE;
          end
        end
        S_ERASE: begin
          if (emit) begin
            state_q <= S_TRACE;
          end
        end
        S_TRACE: begin
          if (emit) begin
            state_q <= S_GRID;
          end
        end
        S_GRID: begin
          if (emit) begin
            if (k_q == K_LAST) begin
              k_q <= KW'(1);
              if (wrap) begin
                state_q <= S_REPORT;
              end else begin
                col_q   <= col_q + CW'(1);
                state_q <= S_IDLE;
              end
            end else begin
              k_q <= k_q + KW'(1);
            end
          end
        end
        S_REPORT: begin
          if (emit) begin
            prev_q  <= peak_q;
            peak_q  <= '0;
            state_q <= S_GRID0;
          end
        end
        S_GRID0: begin
          if (emit) begin
            if (k_q == K_LAST) begin
              k_q     <= KW'(1);
              state_q <= S_WRAP;
            end else begin
              k_q <= k_q + KW'(1);
            end
          end
        end
        S_WRAP: begin
          if (emit) begin
            col_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sample_i.ready     = (state_q == S_IDLE);
  assign cmd_o.valid        = out_valid_q;
  assign cmd_o.command_kind = cmd_q.kind;
  assign cmd_o.start_x      = cmd_q.start_x;
  assign cmd_o.start_y      = cmd_q.start_y;
  assign cmd_o.end_x        = cmd_q.end_x;
  assign cmd_o.end_y        = cmd_q.end_y;
  assign cmd_o.colour       = cmd_q.colour;
  assign cmd_o.shown_peak   = cmd_q.shown_peak;
  assign cmd_o.erased_peak  = cmd_q.erased_peak;
  assign cmd_o.last         = cmd_q.last;

  // While idle, any command still waiting for transfer closes the previous item.
  a_idle_pending_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && out_valid_q) |-> cmd_q.last)
    else $error("idle with a non-final command pending");

  // The scaled row never leaves the screen.
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done) |-> (div_quo <= H_M1))
    else $error("row quotient out of range");

  // The sweep column wraps before reaching the last screen column.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_LAST)
    else $error("column beyond sweep end");

  // The row store is written only when the new row is ready and when the sweep wraps.
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_DIV || state_q == S_WRAP))
    else $error("row store written outside its write phases");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_PREP))
    else $error("sample transfer did not start an item");

endmodule

>>> rtl/core/stpe_ram.sv
module stpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/stpe_div.sv
module stpe_div
  import stpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] rem_q, dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic             fits;

  // Restoring division, one quotient bit per cycle from the top; the quotient
  // never exceeds QUO_W bits because the dividend is at most (height - 1) times
  // the divisor.
  assign fits = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(QUO_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {{(NUM_W-DEN_W-QUO_W+1){1'b0}}, den_i, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
